@@ hdl/dms_pkg.sv @@
// shared constants and types for the descending merge sorter
// no dependencies; imported by dms_cell and descending_merge_sorter
package dms_pkg;

    localparam int VALUE_W   = 32;
    localparam int MAX_ITEMS = 64;
    localparam int COUNT_W   = $clog2(MAX_ITEMS + 1);

    // per-cycle command broadcast to every cell of the chain
    typedef struct packed {
        logic load;   // insert the broadcast value
        logic shift;  // move every value one cell toward the head
    } cell_ctl_t;

    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } sorter_state_t;

endpackage

@@ hdl/dms_cell.sv @@
// one cell of the insertion chain: holds one value, compares against the
// broadcast value and hands its value to a neighbor; depends on dms_pkg
module dms_cell
    import dms_pkg::*;
(
    input  logic                      clk,
    input  cell_ctl_t                 ctl,
    input  logic signed [VALUE_W-1:0] in_value,
    input  logic                      filled,
    input  logic signed [VALUE_W-1:0] left_value,
    input  logic                      left_less,
    input  logic signed [VALUE_W-1:0] right_value,
    output logic signed [VALUE_W-1:0] value,
    output logic                      less
);

    logic signed [VALUE_W-1:0] value_reg;
    logic signed [VALUE_W-1:0] value_next;

    // empty cells count as smaller than anything
    assign less = !filled || (value_reg < in_value);

    always_comb
    begin
        value_next = value_reg;
        if (ctl.load && less)
        begin
            // first smaller cell takes the new value, the rest move down
            value_next = left_less ? left_value : in_value;
        end
        else if (ctl.shift)
        begin
            value_next = right_value;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

@@ hdl/descending_merge_sorter.sv @@
// top level of the descending sorter: cell chain plus load/drain control
// depends on dms_pkg and dms_cell
//
// The block collects a set of signed 32-bit values, one item per clock
// cycle, into a chain of MAX_ITEMS (64) cells that keeps them in
// non-increasing order as they arrive: each new value is compared against
// every cell at once, and the cells holding smaller values step down one
// place to open a slot. Values compare over the full signed range, the most
// negative value included. When the item marked last has been taken, input
// ready drops and the set is streamed out from the head of the chain, one
// result per cycle while out_ready is high, largest first; end_of_set marks
// the smallest, final result. Input is stalled until the final result has
// been taken, since the chain shifts in only one direction at a time. Values
// beyond MAX_ITEMS are dropped and overflowed is high on every result of
// that set; a last item that arrives when the store is full still closes the
// set. After the final result the block is empty and ready for the next set.
// Input ready stays low while reset is held.
module descending_merge_sorter
    import dms_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      last,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [VALUE_W-1:0] sorted_value,
    output logic                      end_of_set,
    output logic                      overflowed
);

    sorter_state_t      state_reg;
    sorter_state_t      state_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               overflow_reg;
    logic               overflow_next;

    cell_ctl_t          ctl;
    logic               in_fire;
    logic               out_fire;
    logic               room;

    logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
    logic                      cell_less  [MAX_ITEMS];

    // no item is taken while reset is held
    assign in_ready  = rst_n && (state_reg == ST_LOAD);
    assign out_valid = (state_reg == ST_DRAIN);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;
    assign room      = (count_reg < COUNT_W'(MAX_ITEMS));

    // chain commands: load only when a slot is free, shift on every result taken
    assign ctl.load  = in_fire && room;
    assign ctl.shift = out_fire;

    // the chain of cells
    for (genvar i = 0; i < MAX_ITEMS; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_value;
        logic                      left_less;
        logic signed [VALUE_W-1:0] right_value;
        logic                      filled;

        // cells below the fill count hold stored values
        assign filled = (count_reg > COUNT_W'(i));

        if (i == 0)
        begin : g_head
            assign left_value = cell_value[i];
            assign left_less  = 1'b0;
        end
        else
        begin : g_body
            assign left_value = cell_value[i-1];
            assign left_less  = cell_less[i-1];
        end

        if (i == MAX_ITEMS - 1)
        begin : g_tail
            // nothing behind the tail; its stale content lies beyond the count
            assign right_value = cell_value[i];
        end
        else
        begin : g_inner
            assign right_value = cell_value[i+1];
        end

        dms_cell u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .in_value    (value),
            .filled      (filled),
            .left_value  (left_value),
            .left_less   (left_less),
            .right_value (right_value),
            .value       (cell_value[i]),
            .less        (cell_less[i])
        );
    end

    // results come straight from the head cell
    assign sorted_value = cell_value[0];
    assign end_of_set   = (count_reg == COUNT_W'(1));
    assign overflowed   = overflow_reg;

    // load / drain control
    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        overflow_next = overflow_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    if (room)
                    begin
                        count_next = count_reg + COUNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    if (last)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (out_fire)
                begin
                    count_next = count_reg - COUNT_W'(1);
                    if (end_of_set)
                    begin
                        state_next    = ST_LOAD;
                        overflow_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next    = ST_LOAD;
                count_next    = '0;
                overflow_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            count_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            overflow_reg <= overflow_next;
        end
    end

    // a set being drained is never empty
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |-> (count_reg != '0))
        else $error("drain with empty chain");

    // fill count never passes the chain length
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(MAX_ITEMS))
        else $error("fill count beyond chain length");

    // the final result leaves the block empty and the overflow mark cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_fire && end_of_set) |=> (count_reg == '0 && !overflow_reg && in_ready))
        else $error("set not closed after final result");

    // a dropped value is remembered until the set ends
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !room) |=> overflow_reg)
        else $error("overflow not recorded");

    // loading and draining never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("load and drain at once");

endmodule

@@ verif/descending_merge_sorter_tb.sv @@
// testbench for descending_merge_sorter: directed and random value sets, every result checked
// depends on dms_pkg and the descending_merge_sorter rtl; self-contained otherwise
module descending_merge_sorter_tb
    import dms_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [VALUE_W-1:0] sval_t;

    // one expected output item
    typedef struct {
        sval_t sorted_value;
        logic  end_of_set;
        logic  overflowed;
    } sorted_result_t;

    localparam sval_t VAL_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
    localparam sval_t VAL_MAX = {1'b0, {(VALUE_W-1){1'b1}}};

    localparam int RANDOM_ITEMS = 480;  // random part stops once this many values went in
    localparam int STALL_LIMIT  = 5000; // cycles with no item moving on either side
    localparam int IDLE_PCT     = 27;   // chance of an idle cycle on each side

    // keeps its own copy of the sorted store and queues the results a closing
    // item should produce; results are compared in order
    class sort_scoreboard;
        sval_t          held[$];        // current set, non-increasing
        logic           overflow_seen;
        sorted_result_t expected[$];
        int             errors;
        int             sets_closed;
        int             overflow_sets;
        int             dropped_values;
        int             values_in;
        int             results_checked;

        function new();
            overflow_seen   = 1'b0;
            errors          = 0;
            sets_closed     = 0;
            overflow_sets   = 0;
            dropped_values  = 0;
            values_in       = 0;
            results_checked = 0;
        endfunction

        function void note_error(string msg);
            errors++;
            if (errors <= 10)
                $display("mismatch: %s", msg);
        endfunction

        // accepted input item: insert or drop, and on the last item queue the set
        function void note_value(sval_t v, logic is_last);
            int             pos;
            sorted_result_t res;
            values_in++;
            if (held.size() < MAX_ITEMS) begin
                pos = held.size();
                while (pos > 0 && held[pos-1] < v)
                    pos--;
                held.insert(pos, v);
            end
            else begin
                overflow_seen = 1'b1;
                dropped_values++;
            end
            if (is_last) begin
                foreach (held[i]) begin
                    res.sorted_value = held[i];
                    res.end_of_set   = (i == held.size() - 1);
                    res.overflowed   = overflow_seen;
                    expected.push_back(res);
                end
                if (overflow_seen)
                    overflow_sets++;
                sets_closed++;
                held.delete();
                overflow_seen = 1'b0;
            end
        endfunction

        // accepted output item against the oldest expectation
        function void check_result(sval_t v, logic eos, logic ovf);
            sorted_result_t want;
            if (expected.size() == 0) begin
                note_error($sformatf("unexpected result value %0d end %b ovf %b", v, eos, ovf));
                return;
            end
            want = expected.pop_front();
            results_checked++;
            if (v !== want.sorted_value || eos !== want.end_of_set
                    || ovf !== want.overflowed)
                note_error($sformatf(
                    "result %0d: expected %0d end %b ovf %b, got %0d end %b ovf %b",
                    results_checked, want.sorted_value, want.end_of_set,
                    want.overflowed, v, eos, ovf));
        endfunction

        function int pending();
            return expected.size();
        endfunction
    endclass

    logic  clk       = 1'b0;
    logic  rst_n     = 1'b0;
    logic  in_valid  = 1'b0;
    logic  in_ready;
    sval_t value     = '0;
    logic  last      = 1'b0;
    logic  out_valid;
    logic  out_ready = 1'b0;
    sval_t sorted_value;
    logic  end_of_set;
    logic  overflowed;

    bit    steady = 1'b0;   // when set neither side idles
    int    stall_cycles = 0;

    sort_scoreboard sb = new();

    descending_merge_sorter uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .sorted_value (sorted_value),
        .end_of_set   (end_of_set),
        .overflowed   (overflowed)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // both handshakes are observed at the rising edge, before any of this
    // edge's nonblocking updates land, so values are the ones the block saw
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
            sb.note_value(value, last);
        if (rst_n && out_valid && out_ready)
            sb.check_result(sorted_value, end_of_set, overflowed);
    end

    // receiver: ready drops at random except in the steady stretch
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // watchdog: counts cycles in which no item moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("stalled for %0d cycles with %0d results outstanding",
                 stall_cycles, sb.pending());
        $display("TB_ERROR");
        $finish;
    end

    // one input item; random idle cycles come first, then valid holds until taken
    task automatic send_item(input sval_t v, input logic is_last);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= is_last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // directed set, last flag on the final value
    task automatic send_values(input sval_t vals[$]);
        foreach (vals[i])
            send_item(vals[i], i == vals.size() - 1);
    endtask

    // mostly full-range values, with extremes and a narrow band that forces ties
    function automatic sval_t rand_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 50)
            return sval_t'($urandom);
        if (pick < 65)
            case ($urandom_range(4))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return '0;
                3:       return '1;
                default: return sval_t'(1);
            endcase
        return sval_t'($urandom_range(8)) - sval_t'(4);
    endfunction

    // small sets dominate, a few fill or overfill the store
    function automatic int rand_set_size();
        int pick;
        pick = $urandom_range(99);
        if (pick < 65)
            return $urandom_range(8, 1);
        if (pick < 85)
            return $urandom_range(32, 9);
        if (pick < 93)
            return $urandom_range(MAX_ITEMS - 1, 33);
        return $urandom_range(MAX_ITEMS + 3, MAX_ITEMS);
    endfunction

    task automatic send_set(input int count);
        for (int i = 0; i < count; i++)
            send_item(rand_value(), i == count - 1);
    endtask

    initial
    begin
        sval_t directed[$];
        int    sent;
        int    set_no;
        int    count;
        bit    paused;
        sent   = 0;
        set_no = 0;
        paused = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // a set of one, and that one the most negative value
        directed = {VAL_MIN};
        send_values(directed);
        // both extremes, zero and its neighbours, repeats of the extremes
        directed = {VAL_MAX, VAL_MIN, sval_t'(0), sval_t'(-1), sval_t'(1), VAL_MIN, VAL_MAX};
        send_values(directed);
        // all equal
        directed = {sval_t'(5), sval_t'(5), sval_t'(5)};
        send_values(directed);
        // rising input: every new value goes to the head of the chain
        directed = {sval_t'(-3), sval_t'(-2), sval_t'(-1), sval_t'(0), sval_t'(1), sval_t'(2)};
        send_values(directed);

        // random sets; the first three hit a full store exactly, a last item
        // dropped because the store is full, and several drops in one set
        while (sent < RANDOM_ITEMS) begin
            case (set_no)
                0:       count = MAX_ITEMS;
                1:       count = MAX_ITEMS + 1;
                2:       count = MAX_ITEMS + 3;
                default: count = rand_set_size();
            endcase
            steady = (sent >= 200 && sent < 320);
            send_set(count);
            sent += count;
            set_no++;
            if (!paused && sent >= 260) begin
                // hold input off until everything queued has come out
                in_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending() != 0);
                paused = 1'b1;
            end
        end
        steady = 1'b0;
        in_valid <= 1'b0;

        // drain, then watch a while longer for stray results
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (2 * MAX_ITEMS + 8) @(posedge clk);

        $display("covered %0d sets (%0d overflowing, %0d values dropped) from %0d values",
                 sb.sets_closed, sb.overflow_sets, sb.dropped_values, sb.values_in);
        $display("checked %0d results, %0d failures", sb.results_checked, sb.errors);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/dms_pkg.sv
hdl/dms_cell.sv
hdl/descending_merge_sorter.sv
verif/descending_merge_sorter_tb.sv
